[hdl/bmh_pkg.sv]
// Package for the binary min-heap priority queue.
// Holds the item types, the cell link types and the status and action codes.
// No dependencies.
package bmh_pkg;

   // Key and field widths.
   localparam int KEY_W = 32;
   localparam int OCC_W = 9;
   localparam int STATUS_W = 2;

   // Default number of keys the queue can hold.
   localparam int CAPACITY_DEFAULT = 256;

   typedef logic signed [KEY_W-1:0] key_type;

   // Action codes carried by an input item.
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_EXTRACT = 1'b1;

   // Status codes carried by a result item.
   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   // Input item.
   typedef struct packed {
      logic action;
      key_type key_in;
   } req_type;

   // Result item.
   typedef struct packed {
      key_type key_out;
      logic [STATUS_W-1:0] status;
      logic [OCC_W-1:0] occupancy;
      logic is_empty;
   } rsp_type;

   // Command broadcast to every cell in the chain.
   typedef struct packed {
      logic insert;
      logic extract;
      key_type key;
   } cell_cmd_type;

   // What one cell shows its neighbors.
   typedef struct packed {
      key_type key;
      logic valid;
      logic lt;
   } cell_link_type;

endpackage

[hdl/bmh_cell.sv]
// One cell of the sorted chain that holds the queue's keys.
// Depends on bmh_pkg for the command and link types.
module bmh_cell
   import bmh_pkg::*;
(
   input logic clock,
   input logic reset,
   input cell_cmd_type cmd,
   input cell_link_type left,
   input cell_link_type right,
   output cell_link_type link
);

   key_type key_ff, key_in;
   logic valid_ff, valid_in;
   logic lt;

   // The new key goes ahead of this cell's key when it is strictly smaller
   // or when the cell is empty, so equal keys keep their order.
   assign lt = !valid_ff || (cmd.key < key_ff);

   // Insert shifts the larger keys one cell to the right; extract shifts all
   // keys one cell to the left.
   always_comb begin
      key_in = key_ff;
      valid_in = valid_ff;
      if (cmd.insert) begin
         if (lt) begin
            if (left.lt) begin
               key_in = left.key;
               valid_in = left.valid;
            end else begin
               key_in = cmd.key;
               valid_in = 1'b1;
            end
         end
      end else if (cmd.extract) begin
         key_in = right.key;
         valid_in = right.valid;
      end
   end

   // Key storage; only the valid bit is cleared by reset.
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign link.key = key_ff;
   assign link.valid = valid_ff;
   assign link.lt = lt;

endmodule

[hdl/binary_min_heap_priority_queue_top.sv]
// Top level of the min-priority queue over signed 32-bit keys.
// Depends on bmh_pkg and instantiates a chain of bmh_cell.
//
// The queue takes one item per clock cycle as long as no waiting result is
// stalled, and presents its result from the result register in the cycle
// after acceptance. A new item is taken while the
// previous result still waits, as long as that result is taken in the same
// cycle. Keys are held in ascending order in CAPACITY cells: an insert
// broadcasts the key to all cells, and each cell either keeps its key, takes
// the new key or takes its left neighbor's key; an extract shifts the chain
// left by one. An extract from an empty queue returns status empty and key
// zero; an insert into a full queue returns status full and drops the key.
// There is no clearing pass after reset.
module binary_min_heap_priority_queue_top
   import bmh_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
)
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic accept;
   logic is_insert;
   logic full;
   logic empty;
   cell_cmd_type cmd;
   cell_link_type links [CAPACITY];
   cell_link_type head;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W+OCC_W-1:0] count_wide;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // The result register frees up when its item is taken.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;

   assign is_insert = (req_data.action == ACT_INSERT);
   assign full = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   // Command broadcast to the chain.
   assign cmd.insert = accept && is_insert && !full;
   assign cmd.extract = accept && !is_insert && !empty;
   assign cmd.key = req_data.key_in;

   // Chain of cells, ends tied off.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_type left_link;
      cell_link_type right_link;
      if (i == 0) begin : g_first
         assign left_link = '{key: '0, valid: 1'b1, lt: 1'b0};
      end else begin : g_mid_left
         assign left_link = links[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_link = '{key: '0, valid: 1'b0, lt: 1'b1};
      end else begin : g_mid_right
         assign right_link = links[i+1];
      end
      bmh_cell u_cell (
         .clock(clock),
         .reset(reset),
         .cmd(cmd),
         .left(left_link),
         .right(right_link),
         .link(links[i])
      );
   end

   assign head = links[0];

   // Fill count after this item.
   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.extract) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Occupancy is reported in its nine bits.
   assign count_wide = {{OCC_W{1'b0}}, count_in};

   // Result item for the accepted input item.
   always_comb begin
      rsp_in.status = STATUS_OK;
      rsp_in.key_out = head.key;
      if (is_insert) begin
         if (full) begin
            rsp_in.status = STATUS_FULL;
         end else if (empty || (req_data.key_in < head.key)) begin
            rsp_in.key_out = req_data.key_in;
         end
      end else if (empty) begin
         rsp_in.status = STATUS_EMPTY;
         rsp_in.key_out = '0;
      end
      rsp_in.occupancy = count_wide[OCC_W-1:0];
      rsp_in.is_empty = (count_in == '0);
   end

   // Output handshake.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and result registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

[hdl/bmh_checker.sv]
// Port-level checks for the min-priority queue, bound to its top level.
// Depends on bmh_pkg and binary_min_heap_priority_queue_top.
module bmh_checker
   import bmh_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
)
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W+OCC_W-1:0] CAP_WIDE = (CNT_W + OCC_W)'(CAPACITY);

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // No result item right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An extract from an empty queue reports an empty queue and key zero.
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_EMPTY |->
         rsp_data.occupancy == '0 && rsp_data.is_empty && rsp_data.key_out == '0)
      else $error("bad result for extract from empty queue");

   // A rejected insert reports a full queue.
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_FULL |->
         rsp_data.occupancy == CAP_WIDE[OCC_W-1:0] && !rsp_data.is_empty)
      else $error("bad result for insert into full queue");

   // An accepted item yields a result item in the next cycle.
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after accepted item");

endmodule

bind binary_min_heap_priority_queue_top bmh_checker #(.CAPACITY(CAPACITY)) u_bmh_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);
